// File: rtl/periodic_task_tick_scheduler_assert.svh
// Assertion macros shared by the scheduler's RTL files.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_ASSERT_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every clock edge outside reset.
`define PTS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("scheduler assertion failed");

// Checks that a consequent holds in the same cycle as its antecedent.
`define PTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler implication failed");

`else

`define PTS_ASSERT(label, clk, rst_n, prop)

`define PTS_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/pts_pkg.sv
// Shared types, constants and helper functions of the periodic task tick scheduler.
package pts_pkg;

    // Table size and the widths that follow from it.
    localparam int MAX_SLOTS  = 16;
    localparam int SLOT_IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W      = $clog2(MAX_SLOTS + 1);

    // Action codes of an input item.
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
    typedef logic [CNT_W-1:0]      slot_cnt_t;

    // Input item.
    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] period;
        logic        has_handler;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [15:0] fired_mask;
        logic [31:0] tick_count;
        logic [4:0]  slot_count;
        logic        add_accepted;
    } out_item_t;

    // One entry of the slot table.
    typedef struct packed {
        logic [31:0] period;
        logic [31:0] counter;
        logic        has_handler;
    } slot_entry_t;

    // Access request from the sequencer to the slot memory.
    typedef struct packed {
        logic        rd_en;
        slot_idx_t   rd_idx;
        logic        wr_en;
        slot_idx_t   wr_idx;
        slot_entry_t wr_data;
    } mem_req_t;

    // Finished result handed from the sequencer to the output register.
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } ctl_result_t;

    // Bit of the fired mask for a slot; slots from 16 on have no bit.
    function automatic logic [15:0] fired_bit(input slot_idx_t idx);
        logic [15:0] mask;
        logic [31:0] idx_wide;
        mask     = '0;
        idx_wide = {{(32 - SLOT_IDX_W){1'b0}}, idx};
        for (int j = 0; j < 16; j++) begin
            if (idx_wide == 32'(j)) begin
                mask[j] = 1'b1;
            end
        end
        return mask;
    endfunction

    // Low five bits of the fill count, as reported in a result.
    function automatic logic [4:0] to_slot_count(input slot_cnt_t cnt);
        logic [CNT_W+4:0] wide;
        wide = {5'b0, cnt};
        return wide[4:0];
    endfunction

endpackage

// File: rtl/pts_slot_mem.sv
// Slot table memory: one write port and one registered read port.
module pts_slot_mem
    import pts_pkg::*;
(
    input  logic        aclk,
    input  mem_req_t    mem_req,
    output slot_entry_t mem_rdata
);

    slot_entry_t mem [MAX_SLOTS];
    slot_entry_t rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (mem_req.wr_en) begin
            mem[mem_req.wr_idx] <= mem_req.wr_data;
        end
    end

    // Registered read port: the data follows in the cycle after the request.
    always_ff @(posedge aclk) begin
        if (mem_req.rd_en) begin
            rdata_reg <= mem[mem_req.rd_idx];
        end
    end

    assign mem_rdata = rdata_reg;

endmodule

// File: rtl/pts_ctrl.sv
// Sequencer of the scheduler: decodes items and walks the slot table on a tick.
`include "periodic_task_tick_scheduler_assert.svh"

module pts_ctrl
    import pts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output mem_req_t    mem_req,
    input  slot_entry_t mem_rdata,
    output ctl_result_t res,
    input  logic        res_ready
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] ticks_reg, ticks_next;
    slot_cnt_t   filled_reg, filled_next;
    slot_cnt_t   scan_cnt_reg, scan_cnt_next;
    logic        rd_valid_reg, rd_valid_next;
    slot_idx_t   rd_idx_reg, rd_idx_next;
    logic [15:0] fired_reg, fired_next;
    logic        accepted_reg, accepted_next;

    logic        in_fire;
    logic        slot_fires;
    logic [31:0] reload_value;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_fire = s_valid && s_ready;

    // Update of the slot that came back from memory this cycle.
    assign slot_fires   = mem_rdata.has_handler && (mem_rdata.counter == 32'd0);
    assign reload_value = slot_fires ? mem_rdata.period : mem_rdata.counter;

    // Next state, memory requests and result bookkeeping.
    always_comb begin
        state_next    = state_reg;
        ticks_next    = ticks_reg;
        filled_next   = filled_reg;
        scan_cnt_next = scan_cnt_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = rd_idx_reg;
        fired_next    = fired_reg;
        accepted_next = accepted_reg;
        mem_req       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    fired_next    = '0;
                    accepted_next = 1'b0;
                    state_next    = ST_DONE;
                    case (s_item.action)
                        ACT_TICK: begin
                            ticks_next    = ticks_reg + 32'd1;
                            scan_cnt_next = '0;
                            state_next    = ST_SCAN;
                        end
                        ACT_ADD: begin
                            if (filled_reg < CNT_W'(MAX_SLOTS)) begin
                                mem_req.wr_en               = 1'b1;
                                mem_req.wr_idx              = filled_reg[SLOT_IDX_W-1:0];
                                mem_req.wr_data.period      = s_item.period;
                                mem_req.wr_data.counter     = s_item.period;
                                mem_req.wr_data.has_handler = s_item.has_handler;
                                filled_next                 = filled_reg + CNT_W'(1);
                                accepted_next               = 1'b1;
                            end
                        end
                        ACT_CLEAR: begin
                            filled_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Issue the read of the next filled slot.
                if (scan_cnt_reg < filled_reg) begin
                    mem_req.rd_en  = 1'b1;
                    mem_req.rd_idx = scan_cnt_reg[SLOT_IDX_W-1:0];
                    rd_idx_next    = scan_cnt_reg[SLOT_IDX_W-1:0];
                    rd_valid_next  = 1'b1;
                    scan_cnt_next  = scan_cnt_reg + CNT_W'(1);
                end
                // Write back the slot read in the previous cycle.
                if (rd_valid_reg) begin
                    mem_req.wr_en               = 1'b1;
                    mem_req.wr_idx              = rd_idx_reg;
                    mem_req.wr_data.period      = mem_rdata.period;
                    mem_req.wr_data.counter     = reload_value - 32'd1;
                    mem_req.wr_data.has_handler = mem_rdata.has_handler;
                    if (slot_fires) begin
                        fired_next = fired_reg | fired_bit(rd_idx_reg);
                    end
                end
                if ((scan_cnt_reg == filled_reg) && !rd_valid_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result offered to the output register.
    always_comb begin
        res.valid             = (state_reg == ST_DONE);
        res.item.fired_mask   = fired_reg;
        res.item.tick_count   = ticks_reg;
        res.item.slot_count   = to_slot_count(filled_reg);
        res.item.add_accepted = accepted_reg;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ticks_reg    <= '0;
            filled_reg   <= '0;
            scan_cnt_reg <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ticks_reg    <= ticks_next;
            filled_reg   <= filled_next;
            scan_cnt_reg <= scan_cnt_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // Result fields and the index of the slot in flight.
    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        fired_reg    <= fired_next;
        accepted_reg <= accepted_next;
    end

    // The slot being written back is never the one being read.
    `PTS_ASSERT_IMPL(a_no_rw_overlap, aclk, aresetn,
        mem_req.rd_en && mem_req.wr_en, mem_req.rd_idx != mem_req.wr_idx)

    // The fill count never passes the table size.
    `PTS_ASSERT(a_fill_bound, aclk, aresetn, filled_reg <= CNT_W'(MAX_SLOTS))

    // Returning read data is only expected during a table walk.
    `PTS_ASSERT_IMPL(a_rd_in_scan, aclk, aresetn, rd_valid_reg, state_reg == ST_SCAN)

    // The walk never reads past the filled part of the table.
    `PTS_ASSERT_IMPL(a_scan_bound, aclk, aresetn,
        state_reg == ST_SCAN, scan_cnt_reg <= filled_reg)

endmodule

// File: rtl/periodic_task_tick_scheduler.sv
// Top level of the periodic task tick scheduler with its output register.
//
// A table of MAX_SLOTS periodic task slots, kept in a single-port-read,
// single-port-write memory. An add, a clear or an unused action code passes
// from the idle state straight to the done state; the block accepts again
// once the result is taken into the output register. A tick item walks the
// filled slots through the memory's one read port, one slot per cycle, and
// writes each back after its read returns. Every item gives one
// result item, which is held in an output register so that the next item can
// be accepted while the result waits to be taken; while that register still
// holds an untaken result, the next result waits and the input stalls. The
// table needs no clearing pass after reset.
module periodic_task_tick_scheduler
    import pts_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    mem_req_t    mem_req;
    slot_entry_t mem_rdata;
    ctl_result_t res;
    logic        res_ready;
    logic        m_valid_reg;
    out_item_t   m_item_reg;

    pts_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res       (res),
        .res_ready (res_ready)
    );

    pts_slot_mem u_slot_mem (
        .aclk      (aclk),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    // The output register takes a new result when empty or being drained.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid && res_ready) begin
            m_item_reg <= res.item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
